// ----- rtl/cscu_pkg.sv -----
// Shared types, constants and small lookup functions of the calendar seconds converter.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package cscu_pkg;

  // Number of register stages from input acceptance to the output register.
  localparam int NUM_STAGES = 8;

  // Stream widths, packed fields rounded up to whole bytes.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  // Seconds in one day, and the reciprocals used for division by constants.
  // s / 86400 is taken as (s >> 7) / 675, floor(2^35 / 675), which may
  // come out one low and is corrected afterwards.
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [25:0] RECIP_675     = 26'd50903316;
  // Exact for a 16-bit dividend: ceil(2^32 / 365).
  localparam logic [23:0] RECIP_365     = 24'd11767034;
  // Exact for a 17-bit dividend: ceil(2^22 / 7).
  localparam logic [19:0] RECIP_7       = 20'd599187;
  // Exact for a 17-bit dividend: ceil(2^30 / 60).
  localparam logic [24:0] RECIP_60_WIDE = 25'd17895698;
  // Exact for an 11-bit dividend: ceil(2^24 / 60).
  localparam logic [18:0] RECIP_60_NARR = 19'd279621;

  // Year offset from 1970 of 2100, the one century year in range that is
  // not a leap year.
  localparam logic [7:0] YO_2100       = 8'd130;
  // 2000 - 1970 taken modulo 256, negated: added to turn an offset from
  // 1970 into an offset from 2000.
  localparam logic [7:0] YO_TO_Y2K     = 8'd226;
  localparam logic [11:0] BASE_YEAR    = 12'd2000;
  localparam logic [20:0] EPOCH_DAYS   = 21'd719499;

  typedef enum logic {
    KIND_SEC_TO_DATE = 1'b0,
    KIND_DATE_TO_SEC = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } date_t;

  // Status of the last pipeline stage as seen by the output side.
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } pipe_sts_t;

  // Day of year (from 0) on which month m (0 is January) starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

  // floor(367 * m / 12) for a March-based month number.
  function automatic logic [8:0] gauss_month_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd458;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Leap year test for a year given as an offset from 1970 (1970..2199).
  function automatic logic leap_offset(input logic [7:0] yo);
    return (yo[1:0] == 2'd2) && (yo != YO_2100);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/calendar_seconds_converter_unit.sv -----
// Top level of the calendar seconds converter: stream ports, pipeline control, result select.
// Depends on cscu_pkg, cscu_pipe_ctrl, cscu_sec2date and cscu_date2sec.
`default_nettype none

// Converts between seconds since 1970-01-01 00:00:00 and a Gregorian date
// and time, one transaction per clock. The input tuser bit selects the
// direction: 0 turns in_tdata's seconds into year (offset from 2000, modulo
// 256), month, day, hour, minute, second and weekday (0 is Sunday); 1 turns
// the date fields into seconds with Gauss's formula, low 32 bits kept, and
// date fields out of range carry over linearly. Every input transaction
// yields exactly one output transaction, in order; the fields that the
// chosen direction does not produce are zero. The block is a pipeline of
// eight register stages; a result is presented on the output from the last
// of them and is taken when the output side is ready. Both directions run
// in parallel in the same stages and a new transaction may enter in every
// cycle while the pipeline is not stalled; the throughput of one
// transaction per cycle comes from replacing each division by the constant
// day, year, week and minute lengths with a multiplication by a reciprocal,
// spread over the stages with a register after each. Every stage holds its
// content while the next one is full and cannot move on, so back-pressure
// on the output stalls the pipeline stage by stage and empty stages keep
// taking new transactions. Reset clears only the stage valid bits.

module calendar_seconds_converter_unit
  import cscu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [31:0] seconds_in, [39:32] year_in, [43:40] month_in, [48:44] day_in,
  // [53:49] hour_in, [59:54] minute_in, [65:60] second_in, [71:66] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] kind: 0 seconds to date, 1 date to seconds
  input  wire logic                   in_tuser,
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [31:0] seconds_out, [39:32] year_out, [43:40] month_out, [48:44] day_out,
  // [53:49] hour_out, [59:54] minute_out, [65:60] second_out,
  // [68:66] weekday_out, [71:69] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic [NUM_STAGES-1:0] en;
  pipe_sts_t             sts;
  date_t                 date_res;
  logic [31:0]           secs_res;
  date_t                 date_sel;
  logic [31:0]           secs_sel;

  // Valid bits and the direction flag travel alongside the datapaths.
  cscu_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (kind_t'(in_tuser)),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .en        (en),
    .sts       (sts)
  );

  cscu_sec2date u_sec2date (
    .clk        (clk),
    .en         (en),
    .seconds_in (in_tdata[31:0]),
    .date_out   (date_res)
  );

  cscu_date2sec u_date2sec (
    .clk         (clk),
    .en          (en),
    .year_in     (in_tdata[39:32]),
    .month_in    (in_tdata[43:40]),
    .day_in      (in_tdata[48:44]),
    .hour_in     (in_tdata[53:49]),
    .minute_in   (in_tdata[59:54]),
    .second_in   (in_tdata[65:60]),
    .seconds_out (secs_res)
  );

  // Only the result of the requested direction is shown; the rest is zero.
  always_comb begin
    if (sts.kind == KIND_DATE_TO_SEC) begin
      secs_sel = secs_res;
      date_sel = '0;
    end else begin
      secs_sel = '0;
      date_sel = date_res;
    end
  end

  assign out_tvalid = sts.valid;
  assign out_tdata  = {3'b000,
                       date_sel.weekday,
                       date_sel.second,
                       date_sel.minute,
                       date_sel.hour,
                       date_sel.day,
                       date_sel.month,
                       date_sel.year,
                       secs_sel};

endmodule

`default_nettype wire

// ----- rtl/cscu_pipe_ctrl.sv -----
// Valid and kind tracking for the converter pipeline, with per-stage load enables.
// Depends on cscu_pkg.
`default_nettype none

module cscu_pipe_ctrl
  import cscu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire kind_t                 in_kind,
  output logic                       in_ready,
  input  wire logic                  out_ready,
  output logic [NUM_STAGES-1:0]      en,
  output pipe_sts_t                  sts
);

  logic [NUM_STAGES-1:0] valid_r;
  kind_t                 kind_r [NUM_STAGES];
  logic [NUM_STAGES:0]   ready;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    ready[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  assign en       = ready[NUM_STAGES-1:0];
  assign in_ready = ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ready[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      kind_r[0] <= in_kind;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        kind_r[k] <= kind_r[k-1];
      end
    end
  end

  assign sts.valid = valid_r[NUM_STAGES-1];
  assign sts.kind  = kind_r[NUM_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/cscu_sec2date.sv -----
// Eight-stage datapath turning seconds since 1970 into a Gregorian date and time.
// Depends on cscu_pkg; stage enables come from cscu_pipe_ctrl.
`default_nettype none

module cscu_sec2date
  import cscu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [NUM_STAGES-1:0] en,
  input  wire logic [31:0]           seconds_in,
  output date_t                      date_out
);

  // Stage 0: estimate of the day count, possibly one low.
  logic [50:0] p0;
  logic [15:0] q0_nxt, q0_r;
  logic [31:0] secs0_r;

  always_comb begin
    p0     = 51'(seconds_in[31:7]) * 51'(RECIP_675);
    q0_nxt = p0[50:35];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q0_r    <= q0_nxt;
      secs0_r <= seconds_in;
    end
  end

  // Stage 1: remainder against the estimate, below two days.
  logic [31:0] t1;
  logic [17:0] r1_nxt, r1_r;
  logic [15:0] q1_r;

  always_comb begin
    t1     = 32'(q0_r) * 32'(SEC_PER_DAY);
    r1_nxt = secs0_r[17:0] - t1[17:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q1_r <= q0_r;
      r1_r <= r1_nxt;
    end
  end

  // Stage 2: correct the day count and the second of the day.
  logic [15:0] days2_nxt, days2_r;
  logic [16:0] rem2_nxt, rem2_r;

  always_comb begin
    if (r1_r >= 18'(SEC_PER_DAY)) begin
      days2_nxt = q1_r + 16'd1;
      rem2_nxt  = 17'(r1_r - 18'(SEC_PER_DAY));
    end else begin
      days2_nxt = q1_r;
      rem2_nxt  = r1_r[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      days2_r <= days2_nxt;
      rem2_r  <= rem2_nxt;
    end
  end

  // Stage 3: year estimate, minute of day and week count.
  logic [39:0] p3_year;
  logic [36:0] p3_week;
  logic [41:0] p3_min;
  logic [16:0] w3;
  logic [7:0]  yo3_nxt, yo3_r;
  logic [14:0] wq3_nxt, wq3_r;
  logic [10:0] mt3_nxt, mt3_r;
  logic [15:0] days3_r;
  logic [16:0] rem3_r;

  always_comb begin
    w3      = 17'(days2_r) + 17'd4;
    p3_year = 40'(days2_r) * 40'(RECIP_365);
    p3_week = 37'(w3) * 37'(RECIP_7);
    p3_min  = 42'(rem2_r) * 42'(RECIP_60_WIDE);
    yo3_nxt = p3_year[39:32];
    wq3_nxt = p3_week[36:22];
    mt3_nxt = p3_min[40:30];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      yo3_r   <= yo3_nxt;
      wq3_r   <= wq3_nxt;
      mt3_r   <= mt3_nxt;
      days3_r <= days2_r;
      rem3_r  <= rem2_r;
    end
  end

  // Stage 4: day within the estimated year, hour, second and weekday.
  logic [8:0]  yp1;
  logic [5:0]  lc4;
  logic [16:0] y365;
  logic [17:0] dfull;
  logic [16:0] ms4;
  logic [29:0] p4_hr;
  logic [16:0] w4;
  logic [16:0] wm4;
  logic [9:0]  d4_nxt, d4_r;
  logic [5:0]  sec4_nxt, sec4_r;
  logic [4:0]  hr4_nxt, hr4_r;
  logic [2:0]  wd4_nxt, wd4_r;
  logic [7:0]  yo4_r;
  logic [10:0] mt4_r;

  always_comb begin
    // Leap years from 1970 up to the year before the estimate; 2100 is skipped.
    yp1      = 9'(yo3_r) + 9'd1;
    lc4      = yp1[7:2] - 6'((yo3_r > YO_2100) ? 1 : 0);
    y365     = 17'(yo3_r) * 17'd365;
    dfull    = 18'(days3_r) - 18'(y365) - 18'(lc4);
    d4_nxt   = dfull[9:0];
    ms4      = 17'(mt3_r) * 17'd60;
    sec4_nxt = rem3_r[5:0] - ms4[5:0];
    p4_hr    = 30'(mt3_r) * 30'(RECIP_60_NARR);
    hr4_nxt  = p4_hr[28:24];
    w4       = 17'(days3_r) + 17'd4;
    wm4      = 17'(wq3_r) * 17'd7;
    wd4_nxt  = w4[2:0] - wm4[2:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d4_r   <= d4_nxt;
      sec4_r <= sec4_nxt;
      hr4_r  <= hr4_nxt;
      wd4_r  <= wd4_nxt;
      yo4_r  <= yo3_r;
      mt4_r  <= mt3_r;
    end
  end

  // Stage 5: step back a year when the estimate overshot, minute of hour.
  logic [7:0]  yo5_nxt, yo5_r;
  logic        leap5_nxt, leap5_r;
  logic [9:0]  dsum5;
  logic [8:0]  d5_nxt, d5_r;
  logic [10:0] mh5;
  logic [5:0]  min5_nxt, min5_r;
  logic [5:0]  sec5_r;
  logic [4:0]  hr5_r;
  logic [2:0]  wd5_r;

  always_comb begin
    if (d4_r[9]) begin
      yo5_nxt = yo4_r - 8'd1;
    end else begin
      yo5_nxt = yo4_r;
    end
    leap5_nxt = leap_offset(yo5_nxt);
    dsum5     = d4_r + 10'd365 + 10'(leap5_nxt);
    d5_nxt    = d4_r[9] ? dsum5[8:0] : d4_r[8:0];
    mh5       = 11'(hr4_r) * 11'd60;
    min5_nxt  = mt4_r[5:0] - mh5[5:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      yo5_r   <= yo5_nxt;
      leap5_r <= leap5_nxt;
      d5_r    <= d5_nxt;
      min5_r  <= min5_nxt;
      sec5_r  <= sec4_r;
      hr5_r   <= hr4_r;
      wd5_r   <= wd4_r;
    end
  end

  // Stage 6: month number from parallel compares against month starts.
  logic [3:0] m6_nxt, m6_r;
  logic [7:0] yo6_r;
  logic       leap6_r;
  logic [8:0] d6_r;
  logic [5:0] min6_r;
  logic [5:0] sec6_r;
  logic [4:0] hr6_r;
  logic [2:0] wd6_r;

  always_comb begin
    m6_nxt = '0;
    for (int k = 1; k < 12; k++) begin
      m6_nxt = m6_nxt + 4'(d5_r >= month_start(4'(k), leap5_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m6_r    <= m6_nxt;
      yo6_r   <= yo5_r;
      leap6_r <= leap5_r;
      d6_r    <= d5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec5_r;
      hr6_r   <= hr5_r;
      wd6_r   <= wd5_r;
    end
  end

  // Stage 7: day of month and the output register.
  logic [8:0] dm7;
  date_t      date7_nxt, date7_r;

  always_comb begin
    dm7               = d6_r - month_start(m6_r, leap6_r) + 9'd1;
    date7_nxt.year    = yo6_r + YO_TO_Y2K;
    date7_nxt.month   = m6_r + 4'd1;
    date7_nxt.day     = dm7[4:0];
    date7_nxt.hour    = hr6_r;
    date7_nxt.minute  = min6_r;
    date7_nxt.second  = sec6_r;
    date7_nxt.weekday = wd6_r;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      date7_r <= date7_nxt;
    end
  end

  assign date_out = date7_r;

endmodule

`default_nettype wire

// ----- rtl/cscu_date2sec.sv -----
// Datapath turning a Gregorian date and time into seconds since 1970, modulo 2^32.
// Depends on cscu_pkg; stage enables come from cscu_pipe_ctrl.
`default_nettype none

module cscu_date2sec
  import cscu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [NUM_STAGES-1:0] en,
  input  wire logic [7:0]            year_in,
  input  wire logic [3:0]            month_in,
  input  wire logic [4:0]            day_in,
  input  wire logic [4:0]            hour_in,
  input  wire logic [5:0]            minute_in,
  input  wire logic [5:0]            second_in,
  output logic [31:0]                seconds_out
);

  // Stage 0: move the year start to March.
  logic [11:0] yf0;
  logic [11:0] y0_nxt, y0_r;
  logic [3:0]  mon0_nxt, mon0_r;
  logic [4:0]  day0_r, hr0_r;
  logic [5:0]  min0_r, sec0_r;

  always_comb begin
    yf0 = BASE_YEAR + 12'(year_in);
    if (month_in <= 4'd2) begin
      mon0_nxt = month_in + 4'd10;
      y0_nxt   = yf0 - 12'd1;
    end else begin
      mon0_nxt = month_in - 4'd2;
      y0_nxt   = yf0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y0_r   <= y0_nxt;
      mon0_r <= mon0_nxt;
      day0_r <= day_in;
      hr0_r  <= hour_in;
      min0_r <= minute_in;
      sec0_r <= second_in;
    end
  end

  // Stage 1: days of whole years, leap days and days of whole months.
  // The year lies in 1999..2255, so its centuries follow from three compares.
  logic [4:0]  c100;
  logic [2:0]  c400;
  logic [20:0] y365_nxt, y365_r;
  logic [9:0]  lp1_nxt, lp1_r;
  logic [8:0]  mt1_nxt, mt1_r;
  logic [4:0]  day1_r, hr1_r;
  logic [5:0]  min1_r, sec1_r;

  always_comb begin
    c100 = 5'd19 + 5'(y0_r >= 12'd2000) + 5'(y0_r >= 12'd2100) + 5'(y0_r >= 12'd2200);
    c400 = 3'd4 + 3'(y0_r >= 12'd2000);
    y365_nxt = 21'(y0_r) * 21'd365;
    lp1_nxt  = y0_r[11:2] - 10'(c100) + 10'(c400);
    mt1_nxt  = gauss_month_days(mon0_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y365_r <= y365_nxt;
      lp1_r  <= lp1_nxt;
      mt1_r  <= mt1_nxt;
      day1_r <= day0_r;
      hr1_r  <= hr0_r;
      min1_r <= min0_r;
      sec1_r <= sec0_r;
    end
  end

  // Stage 2: day count since 1970 and seconds within the day.
  logic [20:0] dsum2;
  logic [16:0] days2_nxt, days2_r;
  logic [16:0] hms2_nxt, hms2_r;

  always_comb begin
    dsum2     = y365_r + 21'(lp1_r) + 21'(mt1_r) + 21'(day1_r) - EPOCH_DAYS;
    days2_nxt = dsum2[16:0];
    hms2_nxt  = 17'(hr1_r) * 17'd3600 + 17'(min1_r) * 17'd60 + 17'(sec1_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      days2_r <= days2_nxt;
      hms2_r  <= hms2_nxt;
    end
  end

  // Stage 3: whole days in seconds, low 32 bits.
  logic [33:0] p3;
  logic [31:0] dsec3_r;
  logic [16:0] hms3_r;

  assign p3 = 34'(days2_r) * 34'(SEC_PER_DAY);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dsec3_r <= p3[31:0];
      hms3_r  <= hms2_r;
    end
  end

  // Stage 4 forms the sum; the remaining stages only carry it along.
  logic [31:0] secs_r [4:NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      secs_r[4] <= dsec3_r + 32'(hms3_r);
    end
    for (int k = 5; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        secs_r[k] <= secs_r[k-1];
      end
    end
  end

  assign seconds_out = secs_r[NUM_STAGES-1];

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for calendar_seconds_converter_unit: random and directed conversions
// in both directions, with an in-bench predictor and randomised stream back-pressure.
// Depends on cscu_pkg and the RTL of the converter.
`timescale 1ns / 100ps

module testbench
  import cscu_pkg::*;
();

  localparam int RANDOM_ITEMS = 850;
  localparam int LIMIT_CYCLES = 200000;
  // Cycles allowed after the last result, well beyond the eight pipeline stages.
  localparam int TAIL_CYCLES  = 20;
  localparam int SHOWN_ERRORS = 10;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned EPOCH_YEAR     = 1970;
  localparam int unsigned CENTURY_BASE   = 2000;
  localparam int unsigned EPOCH_THURSDAY = 4;
  localparam int unsigned LAST_DAY       = 49709;

  // One conversion request as the driver presents it.
  typedef struct {
    kind_t       kind;
    logic [31:0] seconds;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    // The driver holds this request back until every earlier result has come.
    logic        drain_first;
  } conv_request_t;

  // One conversion result, as unpacked from out_tdata.
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] seconds;
    date_t       date;
  } conv_result_t;

  // The receiver's stall behaviour, drawn anew for each phase.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_PATTERN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  conv_request_t pending_requests[$];
  conv_result_t  awaited_results[$];
  conv_request_t cur_req;
  conv_request_t next_req;
  logic          next_valid;
  logic          in_taken = 1'b0;
  int            burst_left = 8;
  int            gap_left = 0;
  rx_mode_t      rx_mode = RX_ALWAYS;
  int            rx_phase_left = 0;
  logic [10:0]   rx_pattern = 11'b10110011101;
  logic          rx_ready;
  conv_result_t  got_result;
  conv_result_t  want_result;
  conv_result_t  fresh_result;
  int            err_cnt = 0;
  int            cycle_cnt = 0;

  calendar_seconds_converter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint leaps_upto(longint y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Length of month m, counted from 0 for January.
  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    case (m)
      1:          return is_leap(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // Seconds since 1970 to calendar date, time of day and weekday.
  function automatic date_t calc_date_from_seconds(logic [31:0] s);
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    longint      d;
    date_t       r;
    days = s / SECS_PER_DAY;
    rem  = s % SECS_PER_DAY;
    yr   = EPOCH_YEAR + days / DAYS_PER_YEAR;
    r.weekday = 3'((days + EPOCH_THURSDAY) % 7);
    // The year estimate can only be one too high; step back when the day goes negative.
    d = longint'(days) - (longint'(yr - EPOCH_YEAR) * longint'(DAYS_PER_YEAR)
        + leaps_upto(longint'(yr) - 1) - leaps_upto(longint'(EPOCH_YEAR) - 1));
    if (d < 0) begin
      yr = yr - 1;
      d  = d + longint'(DAYS_PER_YEAR) + longint'(is_leap(yr));
    end
    for (mon = 0; mon < 11 && d >= longint'(month_days(mon, yr)); mon++)
      d = d - longint'(month_days(mon, yr));
    r.year   = 8'(yr - CENTURY_BASE);
    r.month  = 4'(mon + 1);
    r.day    = 5'(d + 1);
    r.hour   = 5'(rem / SECS_PER_HOUR);
    r.minute = 6'((rem % SECS_PER_HOUR) / 60);
    r.second = 6'(rem % 60);
    return r;
  endfunction

  // Date and time to seconds since 1970 by Gauss's formula, all arithmetic modulo 2^32.
  function automatic logic [31:0] calc_seconds_from_date(logic [7:0] yo, logic [3:0] mo,
                                                         logic [4:0] dy, logic [4:0] hr,
                                                         logic [5:0] mi, logic [5:0] se);
    logic [31:0] y;
    logic [31:0] m;
    logic [31:0] days;
    y = CENTURY_BASE + 32'(yo);
    m = 32'(mo);
    // The year is taken to start in March, so February falls at its end.
    if (m <= 2) begin
      m = m + 10;
      y = y - 1;
    end else begin
      m = m - 2;
    end
    days = y / 4 - y / 100 + y / 400 + 367 * m / 12 + 32'(dy) + y * DAYS_PER_YEAR - 719499;
    return ((days * 24 + 32'(hr)) * 60 + 32'(mi)) * 60 + 32'(se);
  endfunction

  // Every field but drain_first random over its full width, so the fields a direction ignores still toggle.
  function automatic conv_request_t random_request();
    conv_request_t r;
    r.kind        = kind_t'($urandom_range(0, 1));
    r.seconds     = $urandom;
    r.year        = 8'($urandom_range(0, 255));
    r.month       = 4'($urandom_range(0, 15));
    r.day         = 5'($urandom_range(0, 31));
    r.hour        = 5'($urandom_range(0, 31));
    r.minute      = 6'($urandom_range(0, 63));
    r.second      = 6'($urandom_range(0, 63));
    r.drain_first = 1'b0;
    return r;
  endfunction

  task automatic queue_seconds(logic [31:0] s);
    conv_request_t r;
    r = random_request();
    r.kind    = KIND_SEC_TO_DATE;
    r.seconds = s;
    pending_requests.push_back(r);
  endtask

  task automatic queue_date(logic [7:0] yo, logic [3:0] mo, logic [4:0] dy,
                            logic [4:0] hr, logic [5:0] mi, logic [5:0] se);
    conv_request_t r;
    r = random_request();
    r.kind   = KIND_DATE_TO_SEC;
    r.year   = yo;
    r.month  = mo;
    r.day    = dy;
    r.hour   = hr;
    r.minute = mi;
    r.second = se;
    pending_requests.push_back(r);
  endtask

  // Driver: presents requests at the falling edge, in bursts of random length separated by
  // random gaps. A request marked to drain first waits until no result is outstanding.
  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_tvalid && !in_taken;
      next_req   = cur_req;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain_first && awaited_results.size() > 0)) begin
          next_req   = pending_requests.pop_front();
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      cur_req   <= next_req;
      in_tvalid <= next_valid;
      in_tuser  <= next_req.kind;
      in_tdata  <= {6'd0, next_req.second, next_req.minute, next_req.hour, next_req.day,
                    next_req.month, next_req.year, next_req.seconds};
    end
  end

  // Receiver: out_tready follows one of several stall behaviours, including long stretches
  // of constant readiness and stretches where it is seldom ready.
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(20, 120);
      end
      rx_phase_left--;
      rx_pattern = {rx_pattern[0], rx_pattern[10:1]};
      case (rx_mode)
        RX_ALWAYS:  rx_ready = 1'b1;
        RX_PATTERN: rx_ready = rx_pattern[0];
        RX_COIN:    rx_ready = 1'($urandom_range(0, 1));
        default:    rx_ready = ($urandom_range(0, 7) == 0);
      endcase
      out_tready <= rx_ready;
    end
  end

  // Monitor: at each rising edge the accepted input transaction is predicted and queued, and
  // an accepted output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      fresh_result = '0;
      if (cur_req.kind == KIND_SEC_TO_DATE)
        fresh_result.date = calc_date_from_seconds(cur_req.seconds);
      else
        fresh_result.seconds = calc_seconds_from_date(cur_req.year, cur_req.month,
                                                      cur_req.day, cur_req.hour,
                                                      cur_req.minute, cur_req.second);
      awaited_results.push_back(fresh_result);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_result.seconds      = out_tdata[31:0];
      got_result.date.year    = out_tdata[39:32];
      got_result.date.month   = out_tdata[43:40];
      got_result.date.day     = out_tdata[48:44];
      got_result.date.hour    = out_tdata[53:49];
      got_result.date.minute  = out_tdata[59:54];
      got_result.date.second  = out_tdata[65:60];
      got_result.date.weekday = out_tdata[68:66];
      got_result.pad          = out_tdata[71:69];
      if (awaited_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOWN_ERRORS)
          $display("%0t: result transaction with none outstanding, tdata %h", $realtime,
                   out_tdata);
      end else begin
        want_result = awaited_results.pop_front();
        if (got_result.seconds      !== want_result.seconds      ||
            got_result.date.year    !== want_result.date.year    ||
            got_result.date.month   !== want_result.date.month   ||
            got_result.date.day     !== want_result.date.day     ||
            got_result.date.hour    !== want_result.date.hour    ||
            got_result.date.minute  !== want_result.date.minute  ||
            got_result.date.second  !== want_result.date.second  ||
            got_result.date.weekday !== want_result.date.weekday ||
            got_result.pad          !== want_result.pad) begin
          err_cnt++;
          if (err_cnt <= SHOWN_ERRORS) begin
            $display("%0t: mismatch  sec yr mon day h m s wd pad", $realtime);
            $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d %0d", want_result.seconds,
                     want_result.date.year, want_result.date.month, want_result.date.day,
                     want_result.date.hour, want_result.date.minute, want_result.date.second,
                     want_result.date.weekday, want_result.pad);
            $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d", got_result.seconds,
                     got_result.date.year, got_result.date.month, got_result.date.day,
                     got_result.date.hour, got_result.date.minute, got_result.date.second,
                     got_result.date.weekday, got_result.pad);
          end
        end
      end
    end
  end

  // Watchdog: ends a run that has stalled.
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned cat;
    int unsigned tod;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    logic [31:0] secs;

    // Directed conversions from seconds: both ends of the range, a leap day in the
    // seventies, the turn of the century, leap day 2000, the end of a leap year and
    // the non-leap century year 2100.
    queue_seconds(32'd0);
    queue_seconds(32'hFFFF_FFFF);
    queue_seconds(32'd68169600);
    queue_seconds(32'd946684799);
    queue_seconds(32'd946684800);
    queue_seconds(32'd951782400);
    queue_seconds(calc_seconds_from_date(8'd96, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
    queue_seconds(calc_seconds_from_date(8'd100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59));
    queue_seconds(calc_seconds_from_date(8'd100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    // Directed conversions from dates: extremes, leap days, months zero and beyond
    // December, day zero, days beyond the month, and hours, minutes and seconds that roll.
    queue_date(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    queue_date(8'd255, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    queue_date(8'd0, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30);
    queue_date(8'd100, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
    queue_date(8'd5, 4'd0, 5'd15, 5'd6, 6'd7, 6'd8);
    queue_date(8'd7, 4'd13, 5'd1, 5'd1, 6'd1, 6'd1);
    queue_date(8'd7, 4'd14, 5'd10, 5'd2, 6'd2, 6'd2);
    queue_date(8'd7, 4'd15, 5'd20, 5'd3, 6'd3, 6'd3);
    queue_date(8'd3, 4'd3, 5'd0, 5'd10, 6'd0, 6'd0);
    queue_date(8'd3, 4'd4, 5'd31, 5'd10, 6'd0, 6'd0);
    queue_date(8'd9, 4'd6, 5'd10, 5'd31, 6'd63, 6'd63);
    queue_date(8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    queue_date(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);

    // Random part. Seconds are drawn uniformly, near month and day boundaries, and at
    // the edges of days; dates are mostly well formed, with some over the full widths.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      cat = $urandom_range(0, 9);
      if (cat < 2) begin
        queue_seconds($urandom);
      end else if (cat < 4) begin
        dy  = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(27, 31))
                                          : 5'($urandom_range(1, 26));
        tod = $urandom_range(0, 2);
        hr  = (tod == 0) ? 5'd0 : (tod == 1) ? 5'd23 : 5'($urandom_range(0, 23));
        mi  = (tod == 0) ? 6'd0 : (tod == 1) ? 6'd59 : 6'($urandom_range(0, 59));
        se  = (tod == 0) ? 6'd0 : (tod == 1) ? 6'd59 : 6'($urandom_range(0, 59));
        secs = calc_seconds_from_date(8'($urandom_range(0, 105)), 4'($urandom_range(1, 12)),
                                      dy, hr, mi, se);
        queue_seconds(secs + $urandom_range(0, 4) - 2);
      end else if (cat == 4) begin
        tod = $urandom_range(0, 2);
        secs = (tod == 0) ? 0 : (tod == 1) ? SECS_PER_DAY - 1
                                           : $urandom_range(0, SECS_PER_DAY - 1);
        queue_seconds($urandom_range(0, LAST_DAY) * SECS_PER_DAY + secs);
      end else if (cat < 9) begin
        queue_date(8'($urandom_range(0, 255)), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                   6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
      end else begin
        queue_date(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end
      // Now and then the sender waits for the pipeline to empty completely.
      if (i % 200 == 0)
        pending_requests[$].drain_first = 1'b1;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cscu_pkg.sv
rtl/cscu_pipe_ctrl.sv
rtl/cscu_sec2date.sv
rtl/cscu_date2sec.sv
rtl/calendar_seconds_converter_unit.sv
tb/sv/testbench.sv
